// ----- design/ffvd_pkg.sv -----
// Shared types and constants for the form field value decoder.
// Depends on nothing; used by ffvd_step and form_field_value_decoder.
package ffvd_pkg;

  localparam int MAX_KEY_BYTES = 8;
  localparam int NAME_IDX_W    = $clog2(MAX_KEY_BYTES + 1);
  localparam int MAX_RESULTS   = 4;
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 64;

  // Register indexes (byte address is 8 * index)
  localparam logic [1:0] REG_KEY_BYTES  = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_VALUE  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       value_end;
    logic       found;
  } out_item_t;

  typedef struct packed {
    logic [63:0] key_bytes;
    logic [3:0]  key_size;
    logic [7:0]  max_value_bytes;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [NAME_IDX_W-1:0] name_index;
    logic [1:0]            escape_stage;
    logic [7:0]            held_digit;
    logic [7:0]            written_count;
    logic                  found_flag;
  } parse_st_t;

  localparam parse_st_t ST_RESET = '{
    phase:         PH_MATCH,
    name_index:    '0,
    escape_stage:  2'd0,
    held_digit:    8'd0,
    written_count: 8'd0,
    found_flag:    1'b0
  };

  typedef out_item_t [MAX_RESULTS-1:0] res_list_t;

endpackage

// ----- design/ffvd_step.sv -----
// One-item parse step: next parse state and the result list for one body byte.
// Depends on ffvd_pkg.
module ffvd_step (
  input  ffvd_pkg::cfg_t                  cfg,
  input  ffvd_pkg::parse_st_t             st,
  input  ffvd_pkg::in_item_t              item,
  output ffvd_pkg::parse_st_t             st_nxt,
  output ffvd_pkg::res_list_t             res,
  output logic [ffvd_pkg::RES_CNT_W-1:0]  res_cnt
);

  localparam int RES_CNT_W = ffvd_pkg::RES_CNT_W;

  typedef struct packed {
    ffvd_pkg::parse_st_t             st;
    ffvd_pkg::res_list_t             res;
    logic [ffvd_pkg::RES_CNT_W-1:0]  cnt;
  } work_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (c >= "0" && c <= "9") v = c - 8'h30;
    else if (c >= "a" && c <= "f") v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  // Results beyond the list depth are dropped
  function automatic work_t push(work_t w, ffvd_pkg::out_item_t r);
    work_t o;
    o = w;
    if (w.cnt < RES_CNT_W'(ffvd_pkg::MAX_RESULTS)) begin
      o.res[w.cnt[$clog2(ffvd_pkg::MAX_RESULTS)-1:0]] = r;
      o.cnt = w.cnt + 1'b1;
    end
    return o;
  endfunction

  function automatic work_t emit(work_t w, logic [7:0] b, logic [7:0] max_b);
    work_t               o;
    ffvd_pkg::out_item_t r;
    r = '{value_byte: b, byte_valid: 1'b1, value_end: 1'b0, found: 1'b0};
    o = push(w, r);
    o.st.written_count = w.st.written_count + 8'd1;
    if (o.st.written_count >= max_b) begin
      o.st.phase        = ffvd_pkg::PH_DONE;
      o.st.escape_stage = 2'd0;
    end
    return o;
  endfunction

  function automatic work_t take_plain(work_t w, logic [7:0] b, logic [7:0] max_b);
    work_t o;
    o = w;
    if (b == ffvd_pkg::CH_NUL || b == ffvd_pkg::CH_AMP) o.st.phase = ffvd_pkg::PH_DONE;
    else if (b == ffvd_pkg::CH_PLUS) o = emit(w, ffvd_pkg::CH_SPACE, max_b);
    else if (b == ffvd_pkg::CH_PCT) o.st.escape_stage = 2'd1;
    else o = emit(w, b, max_b);
    return o;
  endfunction

  function automatic work_t value_in(work_t w, logic [7:0] b, logic [7:0] max_b);
    work_t o;
    o = w;
    if (w.st.escape_stage == 2'd1) begin
      if (is_hex(b)) begin
        o.st.held_digit   = b;
        o.st.escape_stage = 2'd2;
      end else begin
        o.st.escape_stage = 2'd0;
        o = emit(o, ffvd_pkg::CH_PCT, max_b);
        if (o.st.phase == ffvd_pkg::PH_VALUE) o = take_plain(o, b, max_b);
      end
    end else if (w.st.escape_stage == 2'd2) begin
      o.st.escape_stage = 2'd0;
      if (is_hex(b) && is_hex(w.st.held_digit)) begin
        o = emit(o, {hex_val(w.st.held_digit), hex_val(b)}, max_b);
      end else begin
        // bad pair: literal '%' then both bytes again as plain value bytes
        o = emit(o, ffvd_pkg::CH_PCT, max_b);
        if (o.st.phase == ffvd_pkg::PH_VALUE) o = take_plain(o, w.st.held_digit, max_b);
        if (o.st.phase == ffvd_pkg::PH_VALUE) o = take_plain(o, b, max_b);
      end
    end else begin
      o = take_plain(w, b, max_b);
    end
    return o;
  endfunction

  function automatic work_t name_in(work_t w, logic [7:0] b, ffvd_pkg::cfg_t c);
    work_t                           o;
    logic [ffvd_pkg::NAME_IDX_W-1:0] klen;
    logic [7:0]                      kc;
    o    = w;
    klen = (c.key_size > 4'(ffvd_pkg::MAX_KEY_BYTES))
         ? ffvd_pkg::NAME_IDX_W'(ffvd_pkg::MAX_KEY_BYTES)
         : ffvd_pkg::NAME_IDX_W'(c.key_size);
    kc   = c.key_bytes[8*w.st.name_index[2:0] +: 8];
    if (b == ffvd_pkg::CH_NUL) begin
      o.st.phase = ffvd_pkg::PH_DONE;
    end else if (w.st.phase == ffvd_pkg::PH_SKIP) begin
      if (b == ffvd_pkg::CH_AMP) begin
        o.st.phase      = ffvd_pkg::PH_MATCH;
        o.st.name_index = '0;
      end
    end else if (w.st.name_index < klen) begin
      if (b == kc) o.st.name_index = w.st.name_index + 1'b1;
      else if (b == ffvd_pkg::CH_AMP) o.st.name_index = '0;
      else o.st.phase = ffvd_pkg::PH_SKIP;
    end else if (b == ffvd_pkg::CH_EQ) begin
      o.st.found_flag    = 1'b1;
      o.st.written_count = 8'd0;
      o.st.escape_stage  = 2'd0;
      o.st.phase = (c.max_value_bytes == 8'd0) ? ffvd_pkg::PH_DONE : ffvd_pkg::PH_VALUE;
    end else if (b == ffvd_pkg::CH_AMP) begin
      o.st.name_index = '0;
    end else begin
      o.st.phase = ffvd_pkg::PH_SKIP;
    end
    return o;
  endfunction

  function automatic work_t feed(work_t w, logic [7:0] b, ffvd_pkg::cfg_t c);
    work_t o;
    o = w;
    if (w.st.phase == ffvd_pkg::PH_MATCH || w.st.phase == ffvd_pkg::PH_SKIP)
      o = name_in(w, b, c);
    else if (w.st.phase == ffvd_pkg::PH_VALUE)
      o = value_in(w, b, c.max_value_bytes);
    return o;
  endfunction

  work_t               w;
  ffvd_pkg::out_item_t marker;

  always_comb begin
    w     = '0;
    w.st  = st;
    w     = feed(w, item.body_byte, cfg);
    marker = '{value_byte: 8'd0, byte_valid: 1'b0, value_end: 1'b1, found: 1'b0};
    if (item.body_last) begin
      // body end acts as a trailing zero byte, then the end marker
      w            = feed(w, ffvd_pkg::CH_NUL, cfg);
      marker.found = w.st.found_flag;
      w            = push(w, marker);
      w.st         = ffvd_pkg::ST_RESET;
    end
  end

  assign st_nxt  = w.st;
  assign res     = w.res;
  assign res_cnt = w.cnt;

endmodule

// ----- design/form_field_value_decoder.sv -----
// Top level of the form field value decoder: config registers, input register,
// result list buffer. Depends on ffvd_pkg and ffvd_step.
//
// Streams the bytes of a form-encoded body (one byte per transfer on in_*) and
// picks out the value of the first field whose name equals key_bytes/key_size,
// decoding '+' and %XX escapes on the fly. Each body byte yields zero to four
// result transfers on out_*: decoded bytes (byte_valid=1) and, on the byte
// flagged body_last, one end marker (value_end=1, found=key seen). If a byte
// would produce more than four results the trailing ones are dropped. The
// block sustains one byte per cycle for bytes with at most one result while
// out_stall is low; a byte with more results holds the input while the
// four-entry result buffer drains through the single output port. Registers
// sit on the APB port at byte addresses 0 (key_bytes, 64 bit), 8 (key_size)
// and 16 (max_value_bytes); writes take effect immediately and should be made
// while the block is idle.
module form_field_value_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  // input byte stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ffvd_pkg::in_item_t                 in_data,
  // decoded result stream
  output logic                               out_valid,
  input  logic                               out_stall,
  output ffvd_pkg::out_item_t                out_data,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ffvd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ffvd_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ffvd_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int NRES   = ffvd_pkg::MAX_RESULTS;
  localparam int CNT_W  = ffvd_pkg::RES_CNT_W;

  // ---------------- configuration registers ----------------
  ffvd_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_bytes       <= 64'd0;
      cfg_r.key_size        <= 4'd4;
      cfg_r.max_value_bytes <= 8'd255;
    end else if (cfg_wr) begin
      case (reg_sel)
        ffvd_pkg::REG_KEY_BYTES:  cfg_r.key_bytes       <= pwdata;
        ffvd_pkg::REG_KEY_LENGTH: cfg_r.key_size        <= pwdata[3:0];
        ffvd_pkg::REG_MAX_VALUE:  cfg_r.max_value_bytes <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ffvd_pkg::REG_KEY_BYTES:  prdata = cfg_r.key_bytes;
      ffvd_pkg::REG_KEY_LENGTH: prdata = {60'd0, cfg_r.key_size};
      ffvd_pkg::REG_MAX_VALUE:  prdata = {56'd0, cfg_r.max_value_bytes};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  ffvd_pkg::in_item_t in_r;
  logic               in_vld_r;
  logic               in_acc;
  logic               out_acc;
  logic               fire;   // input register item is processed this cycle

  // result buffer: entry 0 is presented on the output
  ffvd_pkg::res_list_t res_r;
  logic [CNT_W-1:0]    res_cnt_r;

  assign out_acc  = out_valid && !out_stall;
  // process when the buffer is empty or its last entry leaves now
  assign fire     = in_vld_r && ((res_cnt_r == '0) ||
                                 (res_cnt_r == CNT_W'(1) && out_acc));
  assign in_stall = in_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
  end

  // ---------------- parse step ----------------
  ffvd_pkg::parse_st_t st_r;
  ffvd_pkg::parse_st_t st_nxt;
  ffvd_pkg::res_list_t step_res;
  logic [CNT_W-1:0]    step_cnt;

  ffvd_step u_step (
    .cfg     (cfg_r),
    .st      (st_r),
    .item    (in_r),
    .st_nxt  (st_nxt),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ffvd_pkg::ST_RESET;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // ---------------- result buffer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
    end else if (fire) begin
      res_cnt_r <= step_cnt;
    end else if (out_acc) begin
      res_cnt_r <= res_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= step_res;
    end else if (out_acc) begin
      for (int i = 0; i < NRES - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  assign out_valid = (res_cnt_r != '0);
  assign out_data  = res_r[0];

  // ---------------- assertions ----------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= CNT_W'(NRES))
    else $error("result buffer count out of range");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.value_end) |-> (res_cnt_r == CNT_W'(1) && !out_data.byte_valid))
    else $error("end marker is not the final result of its byte");

  a_body_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_r.body_last) |=> (st_r.phase == ffvd_pkg::PH_MATCH && !st_r.found_flag))
    else $error("parse state not cleared after body end");

  a_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    (!fire && res_cnt_r != '0) |=> (res_cnt_r <= $past(res_cnt_r)))
    else $error("result buffer grew without a processed byte");

endmodule

// ----- test/form_field_value_decoder_tb.sv -----
// Self-checking testbench for form_field_value_decoder: directed bodies, then random
// form bodies under several register settings. Depends on ffvd_pkg and the RTL top.
// Expected output comes from a small predictor class that tracks the parse state.

module form_field_value_decoder_tb;

  // Predictor plus store of decoded bytes and end markers still to arrive.
  class field_value_tracker;
    logic [63:0]          key_bytes;
    logic [3:0]           key_size;
    logic [7:0]           max_value_bytes;
    ffvd_pkg::phase_t     phase;
    logic [3:0]           name_index;
    logic [1:0]           escape_stage;
    logic [7:0]           held_digit;
    logic [7:0]           written_count;
    logic                 found_flag;
    ffvd_pkg::out_item_t  decoded_due[$];
    int                   step_count;
    int                   mismatches;
    int                   compared;

    function new();
      key_bytes       = 64'd0;
      key_size        = 4'd4;
      max_value_bytes = 8'd255;
      mismatches      = 0;
      compared        = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase         = ffvd_pkg::PH_MATCH;
      name_index    = 4'd0;
      escape_stage  = 2'd0;
      held_digit    = 8'd0;
      written_count = 8'd0;
      found_flag    = 1'b0;
    endfunction

    function void write_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        ffvd_pkg::REG_KEY_BYTES:  key_bytes = value;
        ffvd_pkg::REG_KEY_LENGTH: key_size = value[3:0];
        ffvd_pkg::REG_MAX_VALUE:  max_value_bytes = value[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return decoded_due.size();
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
    endfunction

    // At most MAX_RESULTS results per body byte; extras are dropped.
    function void push_out(logic [7:0] b, logic v, logic e, logic f);
      ffvd_pkg::out_item_t r;
      if (step_count >= ffvd_pkg::MAX_RESULTS) return;
      r.value_byte = b;
      r.byte_valid = v;
      r.value_end  = e;
      r.found      = f;
      decoded_due.push_back(r);
      step_count++;
    endfunction

    function void emit(logic [7:0] b);
      push_out(b, 1'b1, 1'b0, 1'b0);
      written_count = written_count + 8'd1;
      if (written_count >= max_value_bytes) begin
        phase        = ffvd_pkg::PH_DONE;
        escape_stage = 2'd0;
      end
    endfunction

    function void take_plain(logic [7:0] b);
      if (b == ffvd_pkg::CH_NUL || b == ffvd_pkg::CH_AMP) begin
        phase = ffvd_pkg::PH_DONE;
      end else if (b == ffvd_pkg::CH_PLUS) begin
        emit(ffvd_pkg::CH_SPACE);
      end else if (b == ffvd_pkg::CH_PCT) begin
        escape_stage = 2'd1;
      end else begin
        emit(b);
      end
    endfunction

    function void value_in(logic [7:0] b);
      int lo;
      int hi;
      if (escape_stage == 2'd1) begin
        if (digit_of(b) >= 0) begin
          held_digit   = b;
          escape_stage = 2'd2;
        end else begin
          escape_stage = 2'd0;
          emit(ffvd_pkg::CH_PCT);
          if (phase == ffvd_pkg::PH_VALUE) take_plain(b);
        end
      end else if (escape_stage == 2'd2) begin
        lo = digit_of(b);
        hi = digit_of(held_digit);
        escape_stage = 2'd0;
        if (lo >= 0 && hi >= 0) begin
          emit({hi[3:0], lo[3:0]});
        end else begin
          // bad second digit: literal '%', then both bytes again as plain text
          emit(ffvd_pkg::CH_PCT);
          if (phase == ffvd_pkg::PH_VALUE) take_plain(held_digit);
          if (phase == ffvd_pkg::PH_VALUE) take_plain(b);
        end
      end else begin
        take_plain(b);
      end
    endfunction

    function void name_in(logic [7:0] b);
      logic [3:0] klen;
      logic [7:0] kc;
      klen = (key_size > ffvd_pkg::MAX_KEY_BYTES) ? 4'(ffvd_pkg::MAX_KEY_BYTES) : key_size;
      if (b == ffvd_pkg::CH_NUL) begin
        phase = ffvd_pkg::PH_DONE;
        return;
      end
      if (phase == ffvd_pkg::PH_SKIP) begin
        if (b == ffvd_pkg::CH_AMP) begin
          phase      = ffvd_pkg::PH_MATCH;
          name_index = 4'd0;
        end
        return;
      end
      if (name_index < klen) begin
        kc = key_bytes[8*name_index[2:0] +: 8];
        if (b == kc) name_index = name_index + 4'd1;
        else if (b == ffvd_pkg::CH_AMP) name_index = 4'd0;
        else phase = ffvd_pkg::PH_SKIP;
      end else if (b == ffvd_pkg::CH_EQ) begin
        found_flag    = 1'b1;
        phase         = ffvd_pkg::PH_VALUE;
        written_count = 8'd0;
        escape_stage  = 2'd0;
        if (max_value_bytes == 8'd0) phase = ffvd_pkg::PH_DONE;
      end else if (b == ffvd_pkg::CH_AMP) begin
        name_index = 4'd0;
      end else begin
        phase = ffvd_pkg::PH_SKIP;
      end
    endfunction

    function void feed(logic [7:0] b);
      if (phase == ffvd_pkg::PH_MATCH || phase == ffvd_pkg::PH_SKIP) name_in(b);
      else if (phase == ffvd_pkg::PH_VALUE) value_in(b);
    endfunction

    // Called for every accepted input transfer.
    function void absorb_body_byte(ffvd_pkg::in_item_t it);
      step_count = 0;
      feed(it.body_byte);
      if (it.body_last) begin
        feed(ffvd_pkg::CH_NUL);
        push_out(8'd0, 1'b0, 1'b1, found_flag);
        clear_parse();
      end
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Called for every accepted result transfer.
    task compare_output(ffvd_pkg::out_item_t got);
      ffvd_pkg::out_item_t want;
      if (decoded_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", got));
        return;
      end
      want = decoded_due.pop_front();
      if (got.value_byte !== want.value_byte)
        flag_mismatch($sformatf("result %0d value_byte %h, want %h",
                                compared, got.value_byte, want.value_byte));
      if (got.byte_valid !== want.byte_valid)
        flag_mismatch($sformatf("result %0d byte_valid %b, want %b",
                                compared, got.byte_valid, want.byte_valid));
      if (got.value_end !== want.value_end)
        flag_mismatch($sformatf("result %0d value_end %b, want %b",
                                compared, got.value_end, want.value_end));
      if (got.found !== want.found)
        flag_mismatch($sformatf("result %0d found %b, want %b",
                                compared, got.found, want.found));
      compared++;
    endtask

    task drop_leftovers();
      while (decoded_due.size() > 0) begin
        void'(decoded_due.pop_front());
        flag_mismatch("expected result never arrived");
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                            clk      = 1'b0;
  logic                            rst_n    = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  ffvd_pkg::in_item_t              in_data  = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  ffvd_pkg::out_item_t             out_data;
  logic                            psel     = 1'b0;
  logic                            penable  = 1'b0;
  logic                            pwrite   = 1'b0;
  logic [ffvd_pkg::CFG_ADDR_W-1:0] paddr    = '0;
  logic [ffvd_pkg::CFG_DATA_W-1:0] pwdata   = '0;
  logic [ffvd_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  form_field_value_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  field_value_tracker tracker;

  // idle rates in percent, changed per stimulus phase
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  int items_sent    = 0;
  int bodies_sent   = 0;
  int settings_used = 0;

  // current key as seen by the body generator
  logic [63:0] key_word;
  int          key_len;
  int          key_eff;
  int          cap;

  logic [7:0] body_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: random stall, decided at each edge for the next cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  // Result monitor: values read right after the edge are the ones the edge saw.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.compare_output(out_data);
  end

  // Safety net against a hung handshake.
  initial begin
    #3000000;
    $display("form_field_value_decoder verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ffvd_pkg::CFG_ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_register(idx, value);
  endtask

  // One input transfer, with a random gap in front. Returns at the accepting edge
  // without touching in_valid, so a follow-on item keeps valid high.
  task automatic send_item(input ffvd_pkg::in_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.absorb_body_byte(it);
    items_sent++;
  endtask

  task automatic send_body();
    ffvd_pkg::in_item_t it;
    int                 i;
    for (i = 0; i < body_q.size(); i++) begin
      it.body_byte = body_q[i];
      it.body_last = (i == body_q.size() - 1);
      send_item(it);
    end
    bodies_sent++;
  endtask

  // Block idle: all results in, then a wait for bytes that made none.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (tracker.pending() > 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Body generation
  // ---------------------------------------------------------------------------

  task automatic queue_text(input string s);
    int i;
    body_q.delete();
    for (i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  // small alphabet so random names often collide with key prefixes
  function automatic logic [7:0] name_char();
    string alphabet;
    alphabet = "abcd01";
    return alphabet[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  task automatic add_name();
    int kind;
    int i;
    int n;
    int pos;
    kind = $urandom_range(0, 7);
    case (kind)
      0, 1, 2: for (i = 0; i < key_eff; i++) body_q.push_back(key_word[8*i +: 8]);
      3: for (i = 0; i < key_eff - 1; i++) body_q.push_back(key_word[8*i +: 8]);
      4: begin
        for (i = 0; i < key_eff; i++) body_q.push_back(key_word[8*i +: 8]);
        body_q.push_back(name_char());
      end
      5: begin
        pos = (key_eff > 0) ? $urandom_range(0, key_eff - 1) : 0;
        for (i = 0; i < key_eff; i++)
          body_q.push_back((i == pos) ? name_char() : key_word[8*i +: 8]);
      end
      6: begin
        n = $urandom_range(1, 4);
        repeat (n) body_q.push_back(name_char());
      end
      default: ;  // empty name
    endcase
  endtask

  task automatic add_value();
    int n;
    int kind;
    n = $urandom_range(0, 5);
    repeat (n) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: body_q.push_back(name_char());
        3: body_q.push_back(8'($urandom_range(1, 255)));
        4: body_q.push_back(ffvd_pkg::CH_PLUS);
        5, 6: begin
          body_q.push_back(ffvd_pkg::CH_PCT);
          body_q.push_back(hex_char());
          body_q.push_back(hex_char());
        end
        7: begin
          body_q.push_back(ffvd_pkg::CH_PCT);
          body_q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          body_q.push_back(ffvd_pkg::CH_PCT);
          body_q.push_back(hex_char());
          body_q.push_back(8'($urandom_range(0, 255)));
        end
        default: body_q.push_back(($urandom_range(0, 3) == 0) ? ffvd_pkg::CH_NUL
                                                               : ffvd_pkg::CH_PCT);
      endcase
    end
  endtask

  // Mostly well-formed "name=value&..." bodies; some raw noise, some cut short.
  task automatic build_body();
    int nf;
    int f;
    int n;
    int cut;
    body_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nf = $urandom_range(1, 3);
    for (f = 0; f < nf; f++) begin
      if (f > 0) body_q.push_back(ffvd_pkg::CH_AMP);
      add_name();
      if ($urandom_range(0, 9) != 0) body_q.push_back(ffvd_pkg::CH_EQ);
      add_value();
    end
    if (body_q.size() == 0) body_q.push_back(8'($urandom_range(0, 255)));
    if (body_q.size() > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, body_q.size() - 1);
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
  endtask

  // Register setting for random phase p; covers long, empty and odd keys and
  // the capacity extremes.
  task automatic pick_setting(input int p);
    int i;
    for (i = 0; i < 8; i++) key_word[8*i +: 8] = name_char();
    case (p)
      0: begin key_len = 1;  cap = 255; end
      1: begin key_len = 8;  cap = 1;   end
      2: begin key_len = 15; cap = 3;   end  // longer than the key register
      3: begin key_len = 0;  cap = 255; end  // empty name matches "="
      4: begin key_len = $urandom_range(1, 8); cap = 0; end
      5: begin key_len = 3;  cap = 2; key_word[15:8] = ffvd_pkg::CH_AMP; end
      6: begin key_len = 8;  cap = $urandom_range(0, 255); key_word = '1; end
      7: begin key_len = 4;  cap = 255; key_word[23:16] = ffvd_pkg::CH_NUL; end
      default: begin key_len = $urandom_range(0, 15); cap = $urandom_range(0, 255); end
    endcase
    key_eff = (key_len > ffvd_pkg::MAX_KEY_BYTES) ? ffvd_pkg::MAX_KEY_BYTES : key_len;
    write_reg(ffvd_pkg::REG_KEY_BYTES, key_word);
    write_reg(ffvd_pkg::REG_KEY_LENGTH, 64'(key_len));
    write_reg(ffvd_pkg::REG_MAX_VALUE, 64'(cap));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int phase_start;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed. Reset key is all zero bytes, which can never match.
    queue_text("a=b");
    send_body();
    settle();

    write_reg(ffvd_pkg::REG_KEY_BYTES, 64'h6B);  // "k"
    write_reg(ffvd_pkg::REG_KEY_LENGTH, 64'd1);
    settings_used++;
    // good escape, plus, bad first digit, bad second digit, escape open at end
    queue_text("k=%4a+%z%4%");
    send_body();
    // mismatched field then '&', held digit pending at body end
    queue_text("x&k=%F");
    send_body();
    // zero ends the text; the byte after it is ignored
    queue_text("k=");
    body_q.push_back(ffvd_pkg::CH_NUL);
    body_q.push_back(8'hFF);
    send_body();
    settle();

    // empty key with zero capacity: found, but no value bytes
    write_reg(ffvd_pkg::REG_KEY_LENGTH, 64'd0);
    write_reg(ffvd_pkg::REG_MAX_VALUE, 64'd0);
    settings_used++;
    queue_text("=ab");
    send_body();
    settle();

    // Random phases: three idle profiles, three settings each.
    for (p = 0; p < 9; p++) begin
      case (p / 3)
        0:       begin in_idle_pct = 22; out_idle_pct = 81; end
        1:       begin in_idle_pct = 81; out_idle_pct = 22; end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      pick_setting(p);
      phase_start = items_sent;
      while (items_sent - phase_start < 36) begin
        build_body();
        send_body();
        // now and then hold the sender until the output side has caught up
        if ($urandom_range(0, 7) == 0 && tracker.pending() > 0) begin
          in_valid <= 1'b0;
          while (tracker.pending() > 0) @(posedge clk);
        end
      end
      settle();
    end

    tracker.drop_leftovers();
    $display("Sent %0d body bytes in %0d bodies over %0d register settings,",
             items_sent, bodies_sent, settings_used);
    $display("with three idle profiles; %0d results compared.", tracker.compared);
    if (tracker.mismatches == 0) begin
      $display("form_field_value_decoder verification clean");
    end else begin
      $display("form_field_value_decoder verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ffvd_pkg.sv
design/ffvd_step.sv
design/form_field_value_decoder.sv
test/form_field_value_decoder_tb.sv
